/* rtl/ctok_pkg.sv */
// Shared request types and code constants for the C token splitter.
`timescale 1ns / 1ps

package ctok_pkg;

    // Input request: one source byte or an end-of-input marker.
    typedef struct packed {
        logic       op;
        logic [7:0] byte_in;
    } t_in_req;

    // Output request: one token byte with its tags.
    typedef struct packed {
        logic [7:0] char_out;
        logic [2:0] kind;
        logic       first_of_token;
        logic       last;
        logic [1:0] error_code;
    } t_out_req;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [2:0] KIND_WORD   = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_OPER   = 3'd2;
    localparam logic [2:0] KIND_CHAR   = 3'd3;
    localparam logic [2:0] KIND_STRING = 3'd4;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_LINEBRK = 2'd2;
    localparam logic [1:0] ERR_UNTERM  = 2'd3;

    // Result queue depth; a step writes at most two entries.
    localparam int QDEPTH = 4;
    localparam int QCNTW  = $clog2(QDEPTH + 1);

endpackage

/* rtl/c_token_splitter.sv */
// Top level of the C token splitter: scanner state machine and result queue.
`timescale 1ns / 1ps

// Streaming C tokenizer. Source bytes enter the input channel one request per cycle
// while o_stall is low (op 0 = byte, op 1 = end of input); each token byte
// leaves as one output request tagged with its kind, first/last marks and an error
// code. White space is skipped, operators follow longest match, and literals keep
// their escapes. A byte whose "last" mark depends on what follows is held inside
// the block and goes out when the next request arrives, so the final byte of a word,
// a number or a still-growing operator appears only after the next byte or an
// end-of-input request. The scanner takes one request per cycle when not stalled;
// one request makes zero, one or two output requests, which land in a four-entry
// result queue in the cycle after acceptance. As long as the output is not stalled,
// the queue drains one request per cycle and the input stalls while three or more
// entries wait, so the sustained rate is one byte per cycle.
module c_token_splitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ctok_pkg::t_in_req  i_data,
    output logic               o_stall,
    output logic               o_valid,
    output ctok_pkg::t_out_req o_data,
    input  logic               i_stall
);

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_WORD  = 4'd1,
        M_NUM   = 4'd2,
        M_LIT   = 4'd3,
        M_MINUS = 4'd4,
        M_PLUS  = 4'd5,
        M_LT    = 4'd6,
        M_LTLT  = 4'd7,
        M_GT    = 4'd8,
        M_GTGT  = 4'd9,
        M_EQFAM = 4'd10,
        M_AMP   = 4'd11,
        M_BAR   = 4'd12
    } t_mode;

    // Scanner state
    t_mode       r_mode, n_mode;
    logic [7:0]  r_held_char, n_held_char;
    logic        r_held_valid, n_held_valid;
    logic [2:0]  r_held_kind, n_held_kind;
    logic        r_held_first, n_held_first;
    logic        r_dot_seen, n_dot_seen;
    logic        r_esc, n_esc;
    logic [7:0]  r_quote, n_quote;

    // Result queue: entry 0 is the head and drives the output.
    ctok_pkg::t_out_req        r_q [ctok_pkg::QDEPTH];
    ctok_pkg::t_out_req        n_q [ctok_pkg::QDEPTH];
    logic [ctok_pkg::QCNTW-1:0] r_cnt, n_cnt;

    logic                       acc;
    logic                       pop;
    logic [ctok_pkg::QCNTW-1:0] cnt_after_pop;

    // Step outputs: held byte (goes first) and the new byte result.
    logic               h_emit, h_last;
    logic [1:0]         h_err;
    logic               b_emit;
    ctok_pkg::t_out_req b_item, h_item, s0, s1;
    logic [1:0]         wr_num;

    logic               do_cont, do_complete, do_brk, do_start;
    logic [7:0]         c;

    function automatic logic f_alpha(input logic [7:0] ch);
        return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") || ch == "_";
    endfunction

    function automatic logic f_digit(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic logic f_space(input logic [7:0] ch);
        return ch == 8'd32 || ch == 8'h0A || ch == 8'h09 || ch == 8'h0B || ch == 8'h0D;
    endfunction

    function automatic logic f_punct(input logic [7:0] ch);
        return ch == "[" || ch == "]" || ch == "(" || ch == ")" || ch == "{" ||
               ch == "}" || ch == "." || ch == "~" || ch == "?" || ch == ":" ||
               ch == "," || ch == ";";
    endfunction

    // Accept while the queue has room for two more entries.
    assign o_stall = (r_cnt > ctok_pkg::QCNTW'(ctok_pkg::QDEPTH - 2));
    assign acc     = i_valid && !o_stall;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[0];
    assign pop     = o_valid && !i_stall;
    assign c       = i_data.byte_in;

    // Scanner step
    always_comb begin
        n_mode       = r_mode;
        n_held_char  = r_held_char;
        n_held_valid = r_held_valid;
        n_held_kind  = r_held_kind;
        n_held_first = r_held_first;
        n_dot_seen   = r_dot_seen;
        n_esc        = r_esc;
        n_quote      = r_quote;
        h_emit       = 1'b0;
        h_last       = 1'b0;
        h_err        = ctok_pkg::ERR_NONE;
        b_emit       = 1'b0;
        b_item       = '0;
        do_cont      = 1'b0;
        do_complete  = 1'b0;
        do_brk       = 1'b0;
        do_start     = 1'b0;

        if (acc && i_data.op == ctok_pkg::OP_FLUSH) begin
            // End of input: close the held byte, flag an open literal, reset.
            h_emit = r_held_valid;
            h_last = 1'b1;
            if (r_mode == M_LIT) begin
                h_err = ctok_pkg::ERR_UNTERM;
                if (!r_held_valid) begin
                    b_emit = 1'b1;
                    b_item = '{char_out: 8'h00, kind: r_held_kind, first_of_token: 1'b0,
                               last: 1'b1, error_code: ctok_pkg::ERR_UNTERM};
                end
            end
            n_mode       = M_IDLE;
            n_held_char  = '0;
            n_held_valid = 1'b0;
            n_held_kind  = '0;
            n_held_first = 1'b0;
            n_dot_seen   = 1'b0;
            n_esc        = 1'b0;
            n_quote      = '0;
        end else if (acc) begin
            unique case (r_mode)
                M_WORD, M_NUM: begin
                    if (f_alpha(c) || f_digit(c)) begin
                        do_cont = 1'b1;
                    end else if (c == "." && r_mode == M_NUM && !r_dot_seen) begin
                        n_dot_seen = 1'b1;
                        do_cont    = 1'b1;
                    end else begin
                        do_brk = 1'b1;
                    end
                end
                M_LIT: begin
                    if (r_esc) begin
                        n_esc   = 1'b0;
                        do_cont = 1'b1;
                    end else if (c == r_quote) begin
                        do_complete = 1'b1;
                    end else if (c == "\\") begin
                        n_esc   = 1'b1;
                        do_cont = 1'b1;
                    end else if (c == 8'h0A || c == 8'h0D) begin
                        // Bare line break: emit the held byte, flag the break itself.
                        h_emit       = r_held_valid;
                        n_held_valid = 1'b0;
                        b_emit       = 1'b1;
                        b_item = '{char_out: c, kind: r_held_kind, first_of_token: 1'b0,
                                   last: 1'b0, error_code: ctok_pkg::ERR_LINEBRK};
                    end else begin
                        do_cont = 1'b1;
                    end
                end
                M_MINUS: begin
                    if (c == ">" || c == "=" || c == "-") do_complete = 1'b1;
                    else do_brk = 1'b1;
                end
                M_PLUS: begin
                    if (c == "+" || c == "=") do_complete = 1'b1;
                    else do_brk = 1'b1;
                end
                M_LT, M_GT: begin
                    if (c == "=") begin
                        do_complete = 1'b1;
                    end else if (c == ((r_mode == M_LT) ? "<" : ">")) begin
                        n_mode  = (r_mode == M_LT) ? M_LTLT : M_GTGT;
                        do_cont = 1'b1;
                    end else begin
                        do_brk = 1'b1;
                    end
                end
                M_LTLT, M_GTGT, M_EQFAM: begin
                    if (c == "=") do_complete = 1'b1;
                    else do_brk = 1'b1;
                end
                M_AMP: begin
                    if (c == "&" || c == "=") do_complete = 1'b1;
                    else do_brk = 1'b1;
                end
                M_BAR: begin
                    if (c == "|" || c == "=") do_complete = 1'b1;
                    else do_brk = 1'b1;
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase
        end

        // Emit the held byte as not-last and hold the new one.
        if (do_cont) begin
            h_emit       = r_held_valid;
            n_held_char  = c;
            n_held_first = 1'b0;
            n_held_valid = 1'b1;
        end

        // New byte ends the token.
        if (do_complete) begin
            h_emit       = r_held_valid;
            b_emit       = 1'b1;
            b_item = '{char_out: c, kind: r_held_kind, first_of_token: 1'b0,
                       last: 1'b1, error_code: ctok_pkg::ERR_NONE};
            n_mode       = M_IDLE;
            n_held_valid = 1'b0;
        end

        // New byte does not fit: close the token, then rescan the byte.
        if (do_brk) begin
            h_emit       = r_held_valid;
            h_last       = 1'b1;
            n_held_valid = 1'b0;
            do_start     = 1'b1;
        end

        if (do_start) begin
            n_mode = M_IDLE;
            if (f_space(c)) begin
                n_mode = M_IDLE;
            end else if (f_alpha(c) || f_digit(c)) begin
                n_held_char  = c;
                n_held_kind  = f_digit(c) ? ctok_pkg::KIND_NUMBER : ctok_pkg::KIND_WORD;
                n_held_first = 1'b1;
                n_held_valid = 1'b1;
                n_dot_seen   = 1'b0;
                n_mode       = f_digit(c) ? M_NUM : M_WORD;
            end else if (c == "'" || c == "\"") begin
                n_held_char  = c;
                n_held_kind  = (c == "'") ? ctok_pkg::KIND_CHAR : ctok_pkg::KIND_STRING;
                n_held_first = 1'b1;
                n_held_valid = 1'b1;
                n_quote      = c;
                n_esc        = 1'b0;
                n_mode       = M_LIT;
            end else if (c == "-" || c == "+" || c == "<" || c == ">" || c == "=" ||
                         c == "!" || c == "/" || c == "*" || c == "%" || c == "^" ||
                         c == "&" || c == "|") begin
                // Possible start of a two- or three-byte operator: hold it.
                n_held_char  = c;
                n_held_kind  = ctok_pkg::KIND_OPER;
                n_held_first = 1'b1;
                n_held_valid = 1'b1;
                priority if (c == "-") n_mode = M_MINUS;
                else if (c == "+") n_mode = M_PLUS;
                else if (c == "<") n_mode = M_LT;
                else if (c == ">") n_mode = M_GT;
                else if (c == "&") n_mode = M_AMP;
                else if (c == "|") n_mode = M_BAR;
                else n_mode = M_EQFAM;
            end else begin
                // Single punctuator or unknown byte: one-byte token at once.
                b_emit = 1'b1;
                b_item = '{char_out: c, kind: ctok_pkg::KIND_OPER, first_of_token: 1'b1,
                           last: 1'b1,
                           error_code: f_punct(c) ? ctok_pkg::ERR_NONE
                                                  : ctok_pkg::ERR_UNKNOWN};
            end
        end
    end

    // Order results: held byte first, then the new byte result.
    always_comb begin
        h_item = '{char_out: r_held_char, kind: r_held_kind, first_of_token: r_held_first,
                   last: h_last, error_code: h_err};
        s0     = h_emit ? h_item : b_item;
        s1     = b_item;
        wr_num = {1'b0, h_emit} + {1'b0, b_emit};
    end

    // Queue update: advance on pop, append new results behind what remains.
    always_comb begin
        cnt_after_pop = r_cnt - ctok_pkg::QCNTW'(pop);
        for (int i = 0; i < ctok_pkg::QDEPTH; i++) begin
            if (pop && i < ctok_pkg::QDEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (wr_num != 2'd0 && ctok_pkg::QCNTW'(i) == cnt_after_pop) begin
                n_q[i] = s0;
            end
            if (wr_num == 2'd2 && ctok_pkg::QCNTW'(i) == cnt_after_pop + 1'b1) begin
                n_q[i] = s1;
            end
        end
        n_cnt = cnt_after_pop + ctok_pkg::QCNTW'(wr_num);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_held_char  <= '0;
            r_held_valid <= 1'b0;
            r_held_kind  <= '0;
            r_held_first <= 1'b0;
            r_dot_seen   <= 1'b0;
            r_esc        <= 1'b0;
            r_quote      <= '0;
            r_cnt        <= '0;
        end else begin
            r_mode       <= n_mode;
            r_held_char  <= n_held_char;
            r_held_valid <= n_held_valid;
            r_held_kind  <= n_held_kind;
            r_held_first <= n_held_first;
            r_dot_seen   <= n_dot_seen;
            r_esc        <= n_esc;
            r_quote      <= n_quote;
            r_cnt        <= n_cnt;
        end
    end

    // Queue never overfills.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ctok_pkg::QCNTW'(ctok_pkg::QDEPTH))
        else $error("result queue overflow");

    // Between tokens nothing is held.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_IDLE |-> !r_held_valid)
        else $error("held byte left while idle");

    // Inside a word, number or operator the current byte is always held.
    a_tok_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != M_IDLE && r_mode != M_LIT) |-> r_held_valid)
        else $error("open token without held byte");

    // End of input returns the scanner to idle.
    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_data.op == ctok_pkg::OP_FLUSH) |=> (r_mode == M_IDLE && !r_esc))
        else $error("scanner not idle after end of input");

endmodule
